[design/mce_pkg.sv]
// ----------------------------------------------------------------------------
// Morse code encoder package
// Shared types, register indexes and the character code table.
// ----------------------------------------------------------------------------
package mce_pkg;

   localparam int CHAR_W    = 8;
   localparam int UNITS_W   = 4;
   localparam int LEN_W     = 3;
   localparam int PAT_W     = 6;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_DOT_UNITS  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DASH_UNITS = 4'd1;

   localparam logic [UNITS_W-1:0] DOT_UNITS_RESET  = 4'd3;
   localparam logic [UNITS_W-1:0] DASH_UNITS_RESET = 4'd7;

   localparam logic [CHAR_W-1:0] LOWER_A    = 8'h61;
   localparam logic [CHAR_W-1:0] LOWER_Z    = 8'h7A;
   localparam logic [CHAR_W-1:0] CASE_DELTA = 8'h20;

   // Elements left aligned, first element in the top bit; 1 is a dash.
   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic [PAT_W-1:0] pattern;
   } sym_type;

   typedef struct packed {
      logic    hit;
      sym_type sym;
   } lookup_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   function automatic lookup_type code_lookup(input logic [CHAR_W-1:0] ch);
      lookup_type res;
      res.hit = 1'b1;
      res.sym = '0;
      case (ch)
         8'h41: res.sym = '{3'd2, 6'b010000}; // A
         8'h42: res.sym = '{3'd4, 6'b100000}; // B
         8'h43: res.sym = '{3'd4, 6'b101000}; // C
         8'h44: res.sym = '{3'd3, 6'b100000}; // D
         8'h45: res.sym = '{3'd1, 6'b000000}; // E
         8'h46: res.sym = '{3'd4, 6'b001000}; // F
         8'h47: res.sym = '{3'd3, 6'b110000}; // G
         8'h48: res.sym = '{3'd4, 6'b000000}; // H
         8'h49: res.sym = '{3'd2, 6'b000000}; // I
         8'h4A: res.sym = '{3'd4, 6'b011100}; // J
         8'h4B: res.sym = '{3'd3, 6'b101000}; // K
         8'h4C: res.sym = '{3'd4, 6'b010000}; // L
         8'h4D: res.sym = '{3'd2, 6'b110000}; // M
         8'h4E: res.sym = '{3'd2, 6'b100000}; // N
         8'h4F: res.sym = '{3'd3, 6'b111000}; // O
         8'h50: res.sym = '{3'd4, 6'b011000}; // P
         8'h51: res.sym = '{3'd4, 6'b110100}; // Q
         8'h52: res.sym = '{3'd3, 6'b010000}; // R
         8'h53: res.sym = '{3'd3, 6'b000000}; // S
         8'h54: res.sym = '{3'd1, 6'b100000}; // T
         8'h55: res.sym = '{3'd3, 6'b001000}; // U
         8'h56: res.sym = '{3'd4, 6'b000100}; // V
         8'h57: res.sym = '{3'd3, 6'b011000}; // W
         8'h58: res.sym = '{3'd4, 6'b100100}; // X
         8'h59: res.sym = '{3'd4, 6'b101100}; // Y
         8'h5A: res.sym = '{3'd4, 6'b110000}; // Z
         8'h31: res.sym = '{3'd5, 6'b011110}; // 1
         8'h32: res.sym = '{3'd5, 6'b001110}; // 2
         8'h33: res.sym = '{3'd5, 6'b000110}; // 3
         8'h34: res.sym = '{3'd5, 6'b000010}; // 4
         8'h35: res.sym = '{3'd5, 6'b000000}; // 5
         8'h36: res.sym = '{3'd5, 6'b100000}; // 6
         8'h37: res.sym = '{3'd5, 6'b110000}; // 7
         8'h38: res.sym = '{3'd5, 6'b111000}; // 8
         8'h39: res.sym = '{3'd5, 6'b111100}; // 9
         8'h30: res.sym = '{3'd5, 6'b111110}; // 0
         8'h2E: res.sym = '{3'd6, 6'b010101}; // period
         8'h2C: res.sym = '{3'd6, 6'b110011}; // comma
         8'h2F: res.sym = '{3'd5, 6'b100100}; // slash
         8'h40: res.sym = '{3'd6, 6'b011010}; // at sign
         8'h3F: res.sym = '{3'd6, 6'b001100}; // question mark
         default: res.hit = 1'b0;
      endcase
      return res;
   endfunction

endpackage

[design/mce_if.sv]
// ----------------------------------------------------------------------------
// Morse code encoder channel interfaces
// Valid/ready channels for characters, elements and register writes.
// ----------------------------------------------------------------------------
interface mce_req_if;
   logic                       valid;
   logic                       ready;
   logic [mce_pkg::CHAR_W-1:0] character;
   modport source (output valid, output character, input ready);
   modport sink   (input valid, input character, output ready);
endinterface

interface mce_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        is_dash;
   logic [mce_pkg::UNITS_W-1:0] duration_units;
   logic [mce_pkg::LEN_W-1:0]   symbol_length;
   logic                        last;
   modport source (output valid, output is_dash, output duration_units,
                   output symbol_length, output last, input ready);
   modport sink   (input valid, input is_dash, input duration_units,
                   input symbol_length, input last, output ready);
endinterface

interface mce_csr_if;
   logic                          valid;
   logic                          ready;
   logic [mce_pkg::CSR_IDX_W-1:0] index;
   logic [mce_pkg::CSR_DAT_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[design/mce_front.sv]
// ----------------------------------------------------------------------------
// Morse code encoder front end
// Folds case, looks up the code and queues symbols; drops unknown characters.
// ----------------------------------------------------------------------------
module mce_front (
   mce_req_if.sink                    req,
   input  mce_pkg::fifo_status_type   fifo_status,
   output logic                       push,
   output mce_pkg::sym_type           push_sym
);
   import mce_pkg::*;

   logic [CHAR_W-1:0] upper_char;
   lookup_type        entry;

   always_comb begin
      upper_char = req.character;
      if (req.character >= LOWER_A && req.character <= LOWER_Z) begin
         upper_char = req.character - CASE_DELTA;
      end
      entry = code_lookup(upper_char);
   end

   // Unknown characters are accepted and dropped without a queue entry.
   assign req.ready = !fifo_status.full;
   assign push      = req.valid && !fifo_status.full && entry.hit;
   assign push_sym  = entry.sym;

endmodule

[design/mce_fifo.sv]
// ----------------------------------------------------------------------------
// Morse code encoder symbol queue
// Two-entry queue between the front end and the element sequencer.
// ----------------------------------------------------------------------------
module mce_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  mce_pkg::sym_type           push_sym,
   input  logic                       pop,
   output mce_pkg::sym_type           pop_sym,
   output mce_pkg::fifo_status_type   status
);
   import mce_pkg::*;

   sym_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_sym;
      end
   end

   assign pop_sym      = mem_ff[rd_ptr_ff];
   assign status.full  = count_ff[1];
   assign status.empty = (count_ff == 2'd0);

endmodule

[design/mce_back.sv]
// ----------------------------------------------------------------------------
// Morse code encoder element sequencer
// Shifts out one element per transaction into a registered result stage.
// ----------------------------------------------------------------------------
module mce_back (
   input  logic                        clock,
   input  logic                        reset,
   input  mce_pkg::fifo_status_type    fifo_status,
   input  mce_pkg::sym_type            pop_sym,
   output logic                        pop,
   input  logic [mce_pkg::UNITS_W-1:0] dot_units,
   input  logic [mce_pkg::UNITS_W-1:0] dash_units,
   mce_rsp_if.source                   rsp
);
   import mce_pkg::*;

   logic               busy_ff, busy_in;
   logic [PAT_W-1:0]   pat_ff, pat_in;
   logic [LEN_W-1:0]   rem_ff, rem_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic               out_valid_ff, out_valid_in;
   logic               is_dash_ff;
   logic [UNITS_W-1:0] duration_ff;
   logic [LEN_W-1:0]   symlen_ff;
   logic               last_ff;
   logic               advance;
   logic               final_elem;

   always_comb begin
      advance    = busy_ff && (!out_valid_ff || rsp.ready);
      final_elem = (rem_ff == LEN_W'(1));
      // Take the next symbol as soon as the current one sends its last element.
      pop        = !fifo_status.empty && (!busy_ff || (advance && final_elem));

      busy_in = busy_ff;
      pat_in  = pat_ff;
      rem_in  = rem_ff;
      len_in  = len_ff;
      if (pop) begin
         busy_in = 1'b1;
         pat_in  = pop_sym.pattern;
         rem_in  = pop_sym.len;
         len_in  = pop_sym.len;
      end else if (advance) begin
         busy_in = !final_elem;
         pat_in  = {pat_ff[PAT_W-2:0], 1'b0};
         rem_in  = rem_ff - LEN_W'(1);
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pat_ff <= pat_in;
      rem_ff <= rem_in;
      len_ff <= len_in;
      if (advance) begin
         is_dash_ff  <= pat_ff[PAT_W-1];
         duration_ff <= pat_ff[PAT_W-1] ? dash_units : dot_units;
         symlen_ff   <= len_ff;
         last_ff     <= final_elem;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.is_dash        = is_dash_ff;
   assign rsp.duration_units = duration_ff;
   assign rsp.symbol_length  = symlen_ff;
   assign rsp.last           = last_ff;

endmodule

[design/morse_code_encoder_top.sv]
// ----------------------------------------------------------------------------
// Morse code encoder top level
// Path: an accepted character passes the symbol queue, the sequencer's shift
// register and its output register before its first element shows. Throughput:
// one element per cycle while symbols are queued and the element channel is not stalled; a code has 1 to 6 elements.
// Reset: synchronous; clears the queue and sequencer, sets dot/dash to 3/7.
// ----------------------------------------------------------------------------
module morse_code_encoder_top (
   input logic       clock,
   input logic       reset,
   mce_req_if.sink   req_bus,
   mce_rsp_if.source rsp_bus,
   mce_csr_if.sink   csr_bus
);
   import mce_pkg::*;

   logic [UNITS_W-1:0] dot_units_ff, dot_units_in;
   logic [UNITS_W-1:0] dash_units_ff, dash_units_in;
   fifo_status_type    fifo_status;
   logic               push;
   sym_type            push_sym;
   logic               pop;
   sym_type            pop_sym;

   // Register writes are always taken; unknown indexes are dropped.
   assign csr_bus.ready = 1'b1;

   always_comb begin
      dot_units_in  = dot_units_ff;
      dash_units_in = dash_units_ff;
      if (csr_bus.valid) begin
         if (csr_bus.index == CSR_DOT_UNITS) begin
            dot_units_in = csr_bus.data[UNITS_W-1:0];
         end else if (csr_bus.index == CSR_DASH_UNITS) begin
            dash_units_in = csr_bus.data[UNITS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_units_ff  <= DOT_UNITS_RESET;
         dash_units_ff <= DASH_UNITS_RESET;
      end else begin
         dot_units_ff  <= dot_units_in;
         dash_units_ff <= dash_units_in;
      end
   end

   mce_front u_front (
      .req         (req_bus),
      .fifo_status (fifo_status),
      .push        (push),
      .push_sym    (push_sym)
   );

   mce_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_sym (push_sym),
      .pop      (pop),
      .pop_sym  (pop_sym),
      .status   (fifo_status)
   );

   mce_back u_back (
      .clock       (clock),
      .reset       (reset),
      .fifo_status (fifo_status),
      .pop_sym     (pop_sym),
      .pop         (pop),
      .dot_units   (dot_units_ff),
      .dash_units  (dash_units_ff),
      .rsp         (rsp_bus)
   );

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Morse code encoder testbench
// Sends characters in bursts, with random gaps in some phases, while the element
// channel stalls on its own pattern in some phases. Between phases it rewrites the dot and dash
// durations. A table-driven scoreboard checks every element in order.
// ----------------------------------------------------------------------------
module testbench;
   import mce_pkg::*;

   localparam int IDLE_LIMIT    = 1000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS   = 20;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_TOP = '1;

   typedef struct packed {
      logic               is_dash;
      logic [UNITS_W-1:0] duration_units;
      logic [LEN_W-1:0]   symbol_length;
      logic               last;
   } element_type;

   class element_scoreboard;
      logic [UNITS_W-1:0] dot_units;
      logic [UNITS_W-1:0] dash_units;
      element_type        pending_q[$];
      int                 errors;

      function new();
         dot_units  = DOT_UNITS_RESET;
         dash_units = DASH_UNITS_RESET;
         errors     = 0;
      endfunction

      // Dots and dashes in send order; empty for anything without a code.
      function string pattern_of(logic [CHAR_W-1:0] ch);
         logic [CHAR_W-1:0] up;
         up = (ch >= LOWER_A && ch <= LOWER_Z) ? ch - CASE_DELTA : ch;
         case (up)
            "A": return ".-";
            "B": return "-...";
            "C": return "-.-.";
            "D": return "-..";
            "E": return ".";
            "F": return "..-.";
            "G": return "--.";
            "H": return "....";
            "I": return "..";
            "J": return ".---";
            "K": return "-.-";
            "L": return ".-..";
            "M": return "--";
            "N": return "-.";
            "O": return "---";
            "P": return ".--.";
            "Q": return "--.-";
            "R": return ".-.";
            "S": return "...";
            "T": return "-";
            "U": return "..-";
            "V": return "...-";
            "W": return ".--";
            "X": return "-..-";
            "Y": return "-.--";
            "Z": return "--..";
            "1": return ".----";
            "2": return "..---";
            "3": return "...--";
            "4": return "....-";
            "5": return ".....";
            "6": return "-....";
            "7": return "--...";
            "8": return "---..";
            "9": return "----.";
            "0": return "-----";
            ".": return ".-.-.-";
            ",": return "--..--";
            "/": return "-..-.";
            "@": return ".--.-.";
            "?": return "..--..";
            default: return "";
         endcase
      endfunction

      // Keep the low nibble; unknown indexes are dropped.
      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] data);
         if (idx == CSR_DOT_UNITS) begin
            dot_units = data[UNITS_W-1:0];
         end else if (idx == CSR_DASH_UNITS) begin
            dash_units = data[UNITS_W-1:0];
         end
      endfunction

      function void note_character(logic [CHAR_W-1:0] ch);
         string code;
         int    n;
         code = pattern_of(ch);
         n    = code.len();
         for (int k = 0; k < n; k++) begin
            element_type e;
            e.is_dash        = (code[k] == "-");
            e.duration_units = e.is_dash ? dash_units : dot_units;
            e.symbol_length  = LEN_W'(n);
            e.last           = (k == n - 1);
            pending_q.push_back(e);
         end
      endfunction

      task report(string msg);
         $display("ERROR at %0t: %s", $time, msg);
         errors++;
      endtask

      task check_element(element_type got);
         element_type want;
         if (pending_q.size() == 0) begin
            report($sformatf("element with nothing pending: dash=%0d units=%0d len=%0d last=%0d",
                             got.is_dash, got.duration_units, got.symbol_length, got.last));
            return;
         end
         want = pending_q.pop_front();
         if (got.is_dash !== want.is_dash)
            report($sformatf("is_dash got %0d want %0d", got.is_dash, want.is_dash));
         if (got.duration_units !== want.duration_units)
            report($sformatf("duration_units got %0d want %0d",
                             got.duration_units, want.duration_units));
         if (got.symbol_length !== want.symbol_length)
            report($sformatf("symbol_length got %0d want %0d",
                             got.symbol_length, want.symbol_length));
         if (got.last !== want.last)
            report($sformatf("last got %0d want %0d", got.last, want.last));
      endtask
   endclass

   logic clock;
   logic reset;

   mce_req_if req_ch ();
   mce_rsp_if rsp_ch ();
   mce_csr_if csr_ch ();

   morse_code_encoder_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch),
      .csr_bus (csr_ch)
   );

   element_scoreboard sb;
   int idle_cycles = 0;
   bit tx_gaps     = 1'b1;
   bit rx_stalls   = 1'b1;
   bit rx_busy     = 1'b0;
   int rx_hold     = 0;

   logic [CHAR_W-1:0] directed_chars [$] = '{
      "A", "a", "z", "E", "T", "H", "Q", "j", "0", "5", "9",
      ".", ",", "/", "@", "?", " ",
      8'h00, 8'hFF, 8'hE1, 8'h60, 8'h7B, 8'h5B
   };

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // When stalls are enabled, alternate open and stalled runs of random length.
   always @(negedge clock) begin
      if (rx_hold == 0) begin
         rx_busy = rx_stalls && !rx_busy;
         rx_hold = rx_busy ? $urandom_range(1, 8) : $urandom_range(1, 12);
      end
      rx_hold--;
      rsp_ch.ready <= !rx_busy;
   end

   always @(posedge clock) begin
      element_type got;
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (csr_ch.valid && csr_ch.ready)
            sb.write_reg(csr_ch.index, csr_ch.data);
         if (req_ch.valid && req_ch.ready)
            sb.note_character(req_ch.character);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.is_dash        = rsp_ch.is_dash;
            got.duration_units = rsp_ch.duration_units;
            got.symbol_length  = rsp_ch.symbol_length;
            got.last           = rsp_ch.last;
            sb.check_element(got);
         end
      end
   end

   initial begin : watchdog
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("morse_code_encoder_top: mismatch");
      $finish;
   end

   task send_char(input logic [CHAR_W-1:0] ch);
      req_ch.valid     <= 1'b1;
      req_ch.character <= ch;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // Hold the sender until every pending element is out, then let the
   // pipeline settle.
   task wait_idle();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (sb.pending_q.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
   endtask

   task set_units(input logic [CSR_DAT_W-1:0] dot_data, input logic [CSR_DAT_W-1:0] dash_data,
                  input logic [CSR_IDX_W-1:0] unused_idx);
      wait_idle();
      write_csr(CSR_DOT_UNITS, dot_data);
      write_csr(unused_idx, CSR_DAT_W'($urandom_range(0, 255)));
      write_csr(CSR_DASH_UNITS, dash_data);
      csr_ch.valid <= 1'b0;
   endtask

   // Mostly coded symbols in either case, the rest raw bytes.
   function automatic logic [CHAR_W-1:0] pick_char();
      string             symbols = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.,/@?";
      logic [CHAR_W-1:0] ch;
      if ($urandom_range(0, 4) == 0)
         return CHAR_W'($urandom_range(0, 255));
      ch = symbols[$urandom_range(0, symbols.len() - 1)];
      if (ch >= "A" && ch <= "Z" && $urandom_range(0, 1) == 1)
         ch = ch + CASE_DELTA;
      return ch;
   endfunction

   task run_random(input int target);
      int                coded;
      int                burst;
      logic [CHAR_W-1:0] ch;
      coded = 0;
      while (coded < target) begin
         burst = $urandom_range(1, 8);
         repeat (burst) begin
            ch = pick_char();
            if (sb.pattern_of(ch) != "")
               coded++;
            send_char(ch);
         end
         if ($urandom_range(0, 19) == 0) begin
            wait_idle();
         end else if (tx_gaps && $urandom_range(0, 2) != 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end
      end
   endtask

   initial begin
      sb                = new();
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.character  = '0;
      csr_ch.valid      = 1'b0;
      csr_ch.index      = '0;
      csr_ch.data       = '0;
      rsp_ch.ready      = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset durations first: the edge characters, then a random run.
      foreach (directed_chars[i])
         send_char(directed_chars[i]);
      run_random(PHASE_ITEMS);

      for (int p = 1; p <= 5; p++) begin
         tx_gaps   = (p != 1 && p != 5);
         rx_stalls = (p != 2 && p != 5);
         case (p)
            1: set_units(8'h01, 8'h0F, CSR_IDX_TOP);
            2: set_units(8'h00, 8'hF0,
                         CSR_IDX_W'($urandom_range(CSR_DASH_UNITS + 1, CSR_IDX_TOP)));
            3: set_units(8'hFF, 8'h31,
                         CSR_IDX_W'($urandom_range(CSR_DASH_UNITS + 1, CSR_IDX_TOP)));
            default: set_units(CSR_DAT_W'($urandom_range(0, 255)),
                               CSR_DAT_W'($urandom_range(0, 255)),
                               CSR_IDX_W'($urandom_range(CSR_DASH_UNITS + 1, CSR_IDX_TOP)));
         endcase
         run_random(PHASE_ITEMS);
      end

      wait_idle();
      if (sb.pending_q.size() != 0)
         sb.report($sformatf("%0d elements never arrived", sb.pending_q.size()));
      if (sb.errors == 0) begin
         $display("morse_code_encoder_top: match");
      end else begin
         $display("morse_code_encoder_top: mismatch");
      end
      $finish;
   end

endmodule

[files.f]
design/mce_pkg.sv
design/mce_if.sv
design/mce_front.sv
design/mce_fifo.sv
design/mce_back.sv
design/morse_code_encoder_top.sv
tb/testbench.sv
